// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// concurrent property checks for the midi file parser, compiled out by
// defining NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define MFEP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MFEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define MFEP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/mfep_pkg.sv -----
// ---------------------------------------------------------------------------
// mfep_pkg
// types and constants shared by the midi file parser modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfep_pkg;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_HDR_ID    = 4'd1,
		PH_HDR_LEN   = 4'd2,
		PH_HDR_SKIP  = 4'd3,
		PH_TRK_ID    = 4'd4,
		PH_TRK_LEN   = 4'd5,
		PH_DELTA     = 4'd6,
		PH_STATUS    = 4'd7,
		PH_NOTE1     = 4'd8,
		PH_NOTE2     = 4'd9,
		PH_CC1       = 4'd10,
		PH_CC2       = 4'd11,
		PH_META_TYPE = 4'd12,
		PH_META_LEN  = 4'd13,
		PH_META_SKIP = 4'd14,
		PH_DONE      = 4'd15
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NOTE_ON  = 3'd0,
		KIND_NOTE_OFF = 3'd1,
		KIND_CC       = 3'd2,
		KIND_TEMPO    = 3'd3,
		KIND_BAD      = 3'd4,
		KIND_END      = 3'd5
	} kind_t;

	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CC       = 4'hB;

	localparam logic [7:0] CHR_M = 8'h4D; // 'M'
	localparam logic [7:0] CHR_T = 8'h54; // 'T'
	localparam logic [7:0] CHR_H = 8'h68; // 'h'
	localparam logic [7:0] CHR_D = 8'h64; // 'd'
	localparam logic [7:0] CHR_R = 8'h72; // 'r'
	localparam logic [7:0] CHR_K = 8'h6B; // 'k'

	typedef struct packed {
		kind_t       event_kind;
		logic [31:0] event_tick;
		logic [3:0]  channel;
		logic [7:0]  note_number;
		logic [7:0]  velocity;
		logic [7:0]  controller;
		logic [7:0]  control_value;
		logic [23:0] tempo_us;
		logic        last_result;
	} result_t;

	// up to two results per byte, second only when the first is there
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} front_push_t;

	// expected chunk id character, "MThd" or "MTrk"
	function automatic logic [7:0] id_char(input logic is_trk, input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = CHR_M;
			2'd1: c = CHR_T;
			2'd2: c = is_trk ? CHR_R : CHR_H;
			2'd3: c = is_trk ? CHR_K : CHR_D;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/mfep_front.sv -----
// ---------------------------------------------------------------------------
// mfep_front
// byte classifier and parse state machine, one byte per accepted word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfep_front import mfep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output front_push_t push
);

	phase_t      phase_q;
	logic [1:0]  index_q;
	logic [31:0] accum_q;
	logic [31:0] skip_q;
	logic [31:0] track_q;
	logic [31:0] tick_q;
	logic [7:0]  status_q;
	logic [7:0]  first_data_q;
	logic [7:0]  meta_type_q;
	logic [23:0] tempo_q;

	phase_t      cur_ph;
	phase_t      ph;
	logic [1:0]  bi;
	logic [31:0] fa;
	logic [31:0] sk;
	logic [31:0] tr;
	logic [31:0] tk;
	logic [7:0]  st;
	logic [7:0]  fd;
	logic [7:0]  mt;
	logic [23:0] tp;
	logic        ev_v;
	result_t     ev;
	logic        trunc;
	logic        fin;
	result_t     bad_r;
	result_t     end_r;

	always_comb begin
		if (first_byte) begin
			cur_ph = PH_HDR_ID;
			bi = '0;
			fa = '0;
			sk = '0;
			tr = '0;
			tk = '0;
			st = '0;
			fd = '0;
			mt = '0;
			tp = '0;
		end else begin
			cur_ph = phase_q;
			bi = index_q;
			fa = accum_q;
			sk = skip_q;
			tr = track_q;
			tk = tick_q;
			st = status_q;
			fd = first_data_q;
			mt = meta_type_q;
			tp = tempo_q;
		end
		ph = cur_ph;
		ev_v = 1'b0;
		ev = '0;
		trunc = 1'b0;
		fin = 1'b0;

		if (cur_ph != PH_IDLE) begin
			// every track byte counts against the track length
			if (cur_ph >= PH_DELTA && cur_ph <= PH_META_SKIP && tr != 32'd0)
				tr = tr - 32'd1;

			unique case (cur_ph)
				PH_IDLE, PH_DONE: begin
				end
				PH_HDR_ID, PH_TRK_ID: begin
					if (data_byte != id_char(cur_ph == PH_TRK_ID, bi)) begin
						ev_v = 1'b1;
						ev.event_kind = KIND_BAD;
						ph = PH_DONE;
					end else if (bi == 2'd3) begin
						bi = '0;
						fa = '0;
						ph = (cur_ph == PH_HDR_ID) ? PH_HDR_LEN : PH_TRK_LEN;
					end else begin
						bi = bi + 2'd1;
					end
				end
				PH_HDR_LEN, PH_TRK_LEN: begin
					fa = {fa[23:0], data_byte};
					if (bi == 2'd3) begin
						bi = '0;
						if (cur_ph == PH_HDR_LEN) begin
							sk = fa;
							ph = (fa == 32'd0) ? PH_TRK_ID : PH_HDR_SKIP;
						end else begin
							tr = fa;
							tk = '0;
							ph = (fa == 32'd0) ? PH_DONE : PH_DELTA;
						end
						fa = '0;
					end else begin
						bi = bi + 2'd1;
					end
				end
				PH_HDR_SKIP: begin
					sk = sk - 32'd1;
					if (sk == 32'd0) begin
						bi = '0;
						ph = PH_TRK_ID;
					end
				end
				PH_DELTA: begin
					fa = {fa[24:0], data_byte[6:0]};
					if (!data_byte[7]) begin
						tk = tk + fa;
						fa = '0;
						ph = PH_STATUS;
					end
				end
				PH_STATUS: begin
					st = data_byte;
					if (data_byte == STATUS_META)
						ph = PH_META_TYPE;
					else if (data_byte[7:4] == NIB_NOTE_ON || data_byte[7:4] == NIB_NOTE_OFF)
						ph = PH_NOTE1;
					else if (data_byte[7:4] == NIB_CC)
						ph = PH_CC1;
					else begin
						fa = '0;
						ph = (tr == 32'd0) ? PH_DONE : PH_DELTA;
					end
				end
				PH_NOTE1, PH_CC1: begin
					fd = data_byte;
					ph = (cur_ph == PH_NOTE1) ? PH_NOTE2 : PH_CC2;
				end
				PH_NOTE2: begin
					ev_v = 1'b1;
					ev.event_kind = (st[7:4] == NIB_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
					ev.event_tick = tk;
					ev.channel = st[3:0];
					ev.note_number = fd;
					ev.velocity = data_byte;
					fa = '0;
					ph = (tr == 32'd0) ? PH_DONE : PH_DELTA;
				end
				PH_CC2: begin
					ev_v = 1'b1;
					ev.event_kind = KIND_CC;
					ev.event_tick = tk;
					ev.channel = st[3:0];
					ev.controller = fd;
					ev.control_value = data_byte;
					fa = '0;
					ph = (tr == 32'd0) ? PH_DONE : PH_DELTA;
				end
				PH_META_TYPE: begin
					mt = data_byte;
					fa = '0;
					ph = PH_META_LEN;
				end
				PH_META_LEN: begin
					fa = {fa[24:0], data_byte[6:0]};
					if (!data_byte[7]) begin
						sk = fa;
						tp = '0;
						// only a full-length tempo meta gets its three bytes captured
						bi = (mt == META_TEMPO && fa >= 32'd3) ? 2'd0 : 2'd3;
						if (fa == 32'd0) begin
							fa = '0;
							ph = (tr == 32'd0) ? PH_DONE : PH_DELTA;
						end else begin
							ph = PH_META_SKIP;
						end
					end
				end
				PH_META_SKIP: begin
					if (bi != 2'd3) begin
						tp = {tp[15:0], data_byte};
						bi = bi + 2'd1;
						if (bi == 2'd3) begin
							ev_v = 1'b1;
							ev.event_kind = KIND_TEMPO;
							ev.event_tick = tk;
							ev.tempo_us = tp;
						end
					end
					sk = sk - 32'd1;
					if (sk == 32'd0) begin
						fa = '0;
						ph = (tr == 32'd0) ? PH_DONE : PH_DELTA;
					end
				end
			endcase

			if (last_byte) begin
				fin = 1'b1;
				trunc = (ph >= PH_HDR_ID && ph <= PH_TRK_LEN);
				ph = PH_IDLE;
				bi = '0;
				fa = '0;
				sk = '0;
				tr = '0;
				tk = '0;
				st = '0;
				fd = '0;
				mt = '0;
				tp = '0;
			end
		end
	end

	always_comb begin
		bad_r = '0;
		bad_r.event_kind = KIND_BAD;
		end_r = '0;
		end_r.event_kind = KIND_END;
		end_r.last_result = 1'b1;

		push.v0 = accept && (ev_v || fin);
		push.v1 = accept && fin && (ev_v || trunc);
		push.r0 = ev_v ? ev : (trunc ? bad_r : end_r);
		push.r0.last_result = !(fin && (ev_v || trunc));
		push.r1 = end_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			index_q <= '0;
			accum_q <= '0;
			skip_q <= '0;
			track_q <= '0;
			tick_q <= '0;
			status_q <= '0;
			first_data_q <= '0;
			meta_type_q <= '0;
			tempo_q <= '0;
		end else if (accept) begin
			phase_q <= ph;
			index_q <= bi;
			accum_q <= fa;
			skip_q <= sk;
			track_q <= tr;
			tick_q <= tk;
			status_q <= st;
			first_data_q <= fd;
			meta_type_q <= mt;
			tempo_q <= tp;
		end
	end

	`MFEP_ASSERT_IMP(a_second_needs_first, clk, arst_n, push.v1, push.v0, "second result without first")
	`MFEP_ASSERT_IMP(a_idle_clean, clk, arst_n, phase_q == PH_IDLE, tick_q == 32'd0 && track_q == 32'd0 && skip_q == 32'd0, "idle parser holds stale counters")

endmodule

// ----- rtl/core/mfep_result_queue.sv -----
// ---------------------------------------------------------------------------
// mfep_result_queue
// result queue with two write slots per cycle and one read, head drives the
// output channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfep_result_queue import mfep_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  front_push_t push,
	input  logic        pop,
	output logic        not_ready,
	output logic        head_valid,
	output result_t     head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

	result_t        mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  wr_ptr_p1;
	logic [PW-1:0]  wr_ptr_p2;
	logic [PW-1:0]  rd_ptr_p1;

	assign wr_ptr_p1 = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
	assign wr_ptr_p2 = (wr_ptr_p1 == LAST_SLOT) ? '0 : wr_ptr_p1 + PW'(1);
	assign rd_ptr_p1 = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);

	// room for two results is kept so any byte can be taken
	assign not_ready = count_q > ROOM_LIMIT;
	assign head_valid = count_q != '0;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.v0)
			mem[wr_ptr_q] <= push.r0;
		if (push.v1)
			mem[wr_ptr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.v1)
				wr_ptr_q <= wr_ptr_p2;
			else if (push.v0)
				wr_ptr_q <= wr_ptr_p1;
			if (pop)
				rd_ptr_q <= rd_ptr_p1;
			count_q <= count_q + CW'(push.v0) + CW'(push.v1) - CW'(pop);
		end
	end

	`MFEP_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count beyond depth")
	`MFEP_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`MFEP_ASSERT_IMP(a_no_overflow, clk, arst_n, push.v1 && !pop, count_q <= ROOM_LIMIT, "double push into full queue")

endmodule

// ----- rtl/core/midi_file_event_parser_unit.sv -----
// ---------------------------------------------------------------------------
// midi_file_event_parser_unit
// standard midi file track parser: header and track chunk checks, delta
// time accumulation, note, control change and tempo event extraction
// ---------------------------------------------------------------------------
// a result is registered into the result queue and reaches the output once the results ahead of it have left
// throughput: one byte per cycle while the result queue has two free slots;
//   results leave one per cycle while out_stall is low, each two-result byte adds
//   one to the fill, so only a run of them stalls the input
// reset: arst_n clears the parse state and empties the queue; the parser
//   then waits for a word with first_byte set
`timescale 1ns / 1ps

module midi_file_event_parser_unit import mfep_pkg::*; #(
	parameter int QUEUE_DEPTH = 4 // result slots, at least 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel, one file byte per word
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [31:0] event_tick,
	output logic [3:0]  channel,
	output logic [7:0]  note_number,
	output logic [7:0]  velocity,
	output logic [7:0]  controller,
	output logic [7:0]  control_value,
	output logic [23:0] tempo_us,
	output logic        last_result
);

	front_push_t push;
	result_t     head;
	logic        in_accept;
	logic        out_accept;

	// a byte is taken whenever the queue can absorb its worst case of two results
	assign in_accept = in_valid && !in_stall;
	assign out_accept = out_valid && !out_stall;

	// front: parse state machine, classifies each byte and builds results
	mfep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.push       (push)
	);

	// back: result queue, decouples parsing from the consumer's stalls
	mfep_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_accept),
		.not_ready  (in_stall),
		.head_valid (out_valid),
		.head       (head)
	);

	// queue head fans out to the result ports
	assign event_kind    = head.event_kind;
	assign event_tick    = head.event_tick;
	assign channel       = head.channel;
	assign note_number   = head.note_number;
	assign velocity      = head.velocity;
	assign controller    = head.controller;
	assign control_value = head.control_value;
	assign tempo_us      = head.tempo_us;
	assign last_result   = head.last_result;

endmodule
